FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SSFMT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ssfmt check failed");

// next-cycle implication, disabled while reset is low
`define SSFMT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ssfmt check failed");

`endif

FILE: hw/rtl/ssfmt_pkg.sv
// shared types, constants and glyph table of the seven-segment formatter
`default_nettype none

package ssfmt_pkg;

  localparam int unsigned DIGIT_COUNT = 4;

  localparam logic [7:0] MINUS_RESET = 8'h40;
  localparam logic [7:0] GLYPH_ZERO  = 8'h3F;
  localparam logic [7:0] SEG_BLANK   = 8'h00;

  localparam logic [7:0] GLYPH [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };

  typedef enum logic [2:0] {
    REQ_RAW       = 3'd0,
    REQ_HEX_DIGIT = 3'd1,
    REQ_COLON     = 3'd2,
    REQ_TIME      = 3'd3,
    REQ_DEC       = 3'd4,
    REQ_HEX       = 3'd5
  } req_type_e;

  typedef logic [DIGIT_COUNT-1:0][7:0] seg_buf_t;

  typedef struct packed {
    req_type_e          req_type;
    logic [2:0]         position;
    logic signed [16:0] operand_value;
    logic [6:0]         hours;
    logic [6:0]         minutes;
    logic               dots_on;
    logic               pad_hours;
    logic [2:0]         pad_count;
  } req_t;

  typedef struct packed {
    logic       keep;
    logic [1:0] start_position;
    logic [2:0] byte_count;
    seg_buf_t   segs;
  } render_t;

  // tens and ones of a 7-bit value, reciprocal multiply by 205 / 2048
  function automatic logic [7:0] split10(input logic [6:0] x);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  rem;
    prod = 15'(x) * 15'd205;
    tens = prod[14:11];
    rem  = x - 7'({3'b0, tens} * 7'd10);
    return {tens, rem[3:0]};
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ssfmt_bcd.sv
// four decimal digits of a 14-bit value by parallel reciprocal multiplies
`default_nettype none

module ssfmt_bcd
  import ssfmt_pkg::*;
(
  input  logic [13:0]                  bin_i,
  output logic [DIGIT_COUNT-1:0][3:0]  digit_o,
  output logic [DIGIT_COUNT-1:0]       nz_o
);

  logic [29:0] p1;
  logic [26:0] p2;
  logic [28:0] p3;
  logic [9:0]  q1;
  logic [6:0]  q2;
  logic [3:0]  q3;
  logic [13:0] r0;
  logic [9:0]  r1;
  logic [6:0]  r2;

  // bin / 10, / 100, / 1000, exact below 10000
  assign p1 = 30'(bin_i) * 30'd52429;
  assign p2 = 27'(bin_i) * 27'd5243;
  assign p3 = 29'(bin_i) * 29'd16778;
  assign q1 = p1[28:19];
  assign q2 = p2[25:19];
  assign q3 = p3[27:24];

  assign r0 = bin_i - 14'({4'b0, q1} * 14'd10);
  assign r1 = q1 - 10'({3'b0, q2} * 10'd10);
  assign r2 = q2 - 7'({3'b0, q3} * 7'd10);

  assign digit_o[0] = r0[3:0];
  assign digit_o[1] = r1[3:0];
  assign digit_o[2] = r2[3:0];
  assign digit_o[3] = q3;

  assign nz_o[0] = (bin_i != '0);
  assign nz_o[1] = (q1 != '0);
  assign nz_o[2] = (q2 != '0);
  assign nz_o[3] = (q3 != '0);

endmodule

`default_nettype wire

FILE: hw/rtl/ssfmt_render.sv
// request decode and new segment buffer for one display request
`default_nettype none

module ssfmt_render
  import ssfmt_pkg::*;
(
  input  req_t     req_i,
  input  seg_buf_t segs_i,
  input  logic [7:0] minus_i,
  output render_t  res_o
);

  logic signed [16:0]           val;
  logic                         neg;
  logic [16:0]                  absv;
  logic                         dec_ovf;
  logic [DIGIT_COUNT-1:0][3:0]  dec_digit;
  logic [DIGIT_COUNT-1:0]       dec_nz;
  logic [15:0]                  hexv;
  logic [7:0]                   hr_split;
  logic [7:0]                   mn_split;
  seg_buf_t                     dec_segs;
  seg_buf_t                     hex_segs;
  seg_buf_t                     minus_segs;
  logic [1:0]                   pos;

  assign val     = req_i.operand_value;
  assign neg     = val[16];
  assign absv    = neg ? 17'(-val) : 17'(val);
  assign dec_ovf = (val > 17'sd9999) || (val < -17'sd999);
  assign hexv    = val[15:0];
  assign pos     = req_i.position[1:0];

  assign hr_split = split10(req_i.hours);
  assign mn_split = split10(req_i.minutes);

  ssfmt_bcd u_bcd (
    .bin_i   (absv[13:0]),
    .digit_o (dec_digit),
    .nz_o    (dec_nz)
  );

  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      minus_segs[i] = minus_i;
      // decimal, digit i counted from the right
      if (dec_nz[i]) begin
        dec_segs[DIGIT_COUNT-1-i] = GLYPH[dec_digit[i]];
      end else if (neg) begin
        dec_segs[DIGIT_COUNT-1-i] = (i > 0 && dec_nz[(i+DIGIT_COUNT-1)%DIGIT_COUNT]) ?
                                    minus_i : SEG_BLANK;
      end else begin
        dec_segs[DIGIT_COUNT-1-i] = (req_i.pad_count > 3'(i)) ? GLYPH_ZERO : SEG_BLANK;
      end
      // hex, digit i counted from the right
      if ((hexv >> (4*i)) != '0) begin
        hex_segs[DIGIT_COUNT-1-i] = GLYPH[hexv[4*i +: 4]];
      end else begin
        hex_segs[DIGIT_COUNT-1-i] = (req_i.pad_count > 3'(i)) ? GLYPH_ZERO : SEG_BLANK;
      end
    end
  end

  always_comb begin
    res_o.keep           = 1'b1;
    res_o.start_position = '0;
    res_o.byte_count     = 3'(DIGIT_COUNT);
    res_o.segs           = segs_i;
    unique case (req_i.req_type)
      REQ_RAW: begin
        res_o.keep           = !req_i.position[2];
        res_o.start_position = pos;
        res_o.byte_count     = 3'd1;
        res_o.segs[pos]      = val[7:0];
      end
      REQ_HEX_DIGIT: begin
        res_o.keep           = !req_i.position[2] && (val[16:4] == '0);
        res_o.start_position = pos;
        res_o.byte_count     = 3'd1;
        res_o.segs[pos]      = GLYPH[val[3:0]];
      end
      REQ_COLON: begin
        res_o.start_position = 2'd1;
        res_o.byte_count     = 3'd1;
        res_o.segs[1]        = {req_i.dots_on, segs_i[1][6:0]};
      end
      REQ_TIME: begin
        res_o.segs[0] = (req_i.pad_hours || req_i.hours >= 7'd10) ?
                        GLYPH[hr_split[7:4]] : SEG_BLANK;
        res_o.segs[1] = GLYPH[hr_split[3:0]] | {req_i.dots_on, 7'b0};
        res_o.segs[2] = GLYPH[mn_split[7:4]];
        res_o.segs[3] = GLYPH[mn_split[3:0]];
      end
      REQ_DEC: begin
        res_o.segs = dec_ovf ? minus_segs : dec_segs;
      end
      REQ_HEX: begin
        res_o.segs = neg ? minus_segs : hex_segs;
      end
      default: begin
        res_o.keep = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/four_digit_seven_segment_formatter_top.sv
// input transactions pass through an input register and a result register to the result
// throughput: one request per cycle, limited only by the output handshake
// ignored requests leave the buffer alone and give no result transaction
// reset: segment buffer cleared to blank, minus pattern set to 0x40, no clearing pass
`default_nettype none

module four_digit_seven_segment_formatter_top
  import ssfmt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // position[2:0], operand_value[19:3], hours[26:20], minutes[33:27],
  // dots_on[34], pad_hours[35], pad_count[38:36], zero[39]
  input  logic [39:0] s_axis_tdata,
  // req_type[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // start_position[1:0], byte_count[4:2], seg_digit0[12:5], seg_digit1[20:13],
  // seg_digit2[28:21], seg_digit3[36:29], zero[39:37]
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  logic       in_vld_q, in_vld_d;
  req_t       req_q;
  seg_buf_t   segs_q;
  logic [7:0] minus_q;
  logic       out_vld_q, out_vld_d;
  logic [1:0] start_q;
  logic [2:0] count_q;
  seg_buf_t   out_segs_q;
  render_t    res;
  logic       out_free;
  logic       adv;
  logic       load;
  logic       in_acc;

  ssfmt_render u_render (
    .req_i   (req_q),
    .segs_i  (segs_q),
    .minus_i (minus_q),
    .res_o   (res)
  );

  assign out_free      = !out_vld_q || m_axis_tready;
  assign adv           = in_vld_q && (!res.keep || out_free);
  assign load          = adv && res.keep;
  assign s_axis_tready = !in_vld_q || adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      segs_q    <= '0;
      minus_q   <= MINUS_RESET;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (load) begin
        segs_q <= res.segs;
      end
      if (cfg_we_i) begin
        minus_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q.req_type      <= req_type_e'(s_axis_tuser);
      req_q.position      <= s_axis_tdata[2:0];
      req_q.operand_value <= s_axis_tdata[19:3];
      req_q.hours         <= s_axis_tdata[26:20];
      req_q.minutes       <= s_axis_tdata[33:27];
      req_q.dots_on       <= s_axis_tdata[34];
      req_q.pad_hours     <= s_axis_tdata[35];
      req_q.pad_count     <= s_axis_tdata[38:36];
    end
    if (load) begin
      start_q    <= res.start_position;
      count_q    <= res.byte_count;
      out_segs_q <= res.segs;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b0, out_segs_q[3], out_segs_q[2], out_segs_q[1],
                          out_segs_q[0], count_q, start_q};

endmodule

`default_nettype wire

FILE: hw/rtl/ssfmt_checker.sv
// port-level checks on the formatter result stream, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module ssfmt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  `SSFMT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `SSFMT_ASSERT_IMPL(a_count_legal, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[4:2] == 3'd1 || m_axis_tdata[4:2] == 3'd4)
  `SSFMT_ASSERT_IMPL(a_full_from_left, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[4:2] == 3'd4, m_axis_tdata[1:0] == 2'd0)
  `SSFMT_ASSERT_IMPL(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[39:37] == 3'd0)

endmodule

bind four_digit_seven_segment_formatter_top ssfmt_checker u_ssfmt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
// self-checking testbench for the four-digit seven-segment formatter
`timescale 1ns / 100ps

module testbench
  import ssfmt_pkg::*;
();

  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;
  localparam logic [7:0] COLON_BIT = 8'h80;
  localparam int unsigned PHASES = 5;
  localparam int unsigned PHASE_ITEMS = 290;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned PRINT_LIMIT = 40;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  pos;
    logic [16:0] operand;
    logic [6:0]  hours;
    logic [6:0]  minutes;
    logic        dots;
    logic        padh;
    logic [2:0]  pad;
  } display_req_t;

  typedef struct packed {
    logic [7:0] d3;
    logic [7:0] d2;
    logic [7:0] d1;
    logic [7:0] d0;
    logic [2:0] span;
    logic [1:0] start;
  } display_res_t;

  typedef struct {
    display_req_t req;
    bit           typed;
    bit           fires;
    display_res_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;

  logic [7:0] digit_glyph [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };
  int corner_operands [14] = '{
    0, 9, 10, 15, 16, 255, 256, 9999, 10000, 65535, -1, -999, -1000, -65536
  };

  logic [7:0]   shadow_segs [4];
  logic [7:0]   shadow_minus;
  display_res_t pending_displays [$];
  bit           gaps_on;
  int unsigned  req_count;
  int unsigned  ignored_count;
  int unsigned  checked_count;
  int unsigned  mismatch_count;
  int unsigned  cycle_count;

  four_digit_seven_segment_formatter_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch at result %0d, %s: got %0h want %0h", checked_count, what, got, want);
  endtask

  function automatic void spell_number(int unsigned v, int unsigned base, int unsigned pad,
                                       bit neg);
    bit done;
    int d;
    done = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!done) begin
        d = 3 - i;
        if (v == 0)
          shadow_segs[d] = (pad > i) ? GLYPH_ZERO : SEG_BLANK;
        else
          shadow_segs[d] = digit_glyph[v % base];
        v = v / base;
        if (v == 0 && neg) begin
          if (d > 0)
            shadow_segs[d - 1] = shadow_minus;
          done = 1'b1;
        end
      end
    end
  endfunction

  function automatic void fill_minus();
    for (int i = 0; i < 4; i++)
      shadow_segs[i] = shadow_minus;
  endfunction

  // updates the shadow buffer; returns 0 when the request is dropped
  function automatic bit render_request(input display_req_t r, output display_res_t res);
    int val;
    res = '0;
    res.start = 2'd0;
    res.span = 3'd4;
    val = int'($signed(r.operand));
    case (r.kind)
      REQ_RAW: begin
        if (r.pos >= 3'd4)
          return 1'b0;
        shadow_segs[r.pos[1:0]] = r.operand[7:0];
        res.start = r.pos[1:0];
        res.span = 3'd1;
      end
      REQ_HEX_DIGIT: begin
        if (r.pos >= 3'd4 || val < 0 || val >= 16)
          return 1'b0;
        shadow_segs[r.pos[1:0]] = digit_glyph[val];
        res.start = r.pos[1:0];
        res.span = 3'd1;
      end
      REQ_COLON: begin
        if (r.dots)
          shadow_segs[1] = shadow_segs[1] | COLON_BIT;
        else
          shadow_segs[1] = shadow_segs[1] & ~COLON_BIT;
        res.start = 2'd1;
        res.span = 3'd1;
      end
      REQ_TIME: begin
        shadow_segs[0] = (r.padh || r.hours >= 10) ? digit_glyph[r.hours / 10] : SEG_BLANK;
        shadow_segs[1] = digit_glyph[r.hours % 10] | (r.dots ? COLON_BIT : SEG_BLANK);
        shadow_segs[2] = digit_glyph[r.minutes / 10];
        shadow_segs[3] = digit_glyph[r.minutes % 10];
      end
      REQ_DEC: begin
        if (val > 9999 || val < -999) begin
          fill_minus();
        end else begin
          for (int i = 0; i < 4; i++)
            shadow_segs[i] = SEG_BLANK;
          if (val < 0)
            spell_number(-val, 10, r.pad, 1'b1);
          else
            spell_number(val, 10, r.pad, 1'b0);
        end
      end
      REQ_HEX: begin
        if (val < 0)
          fill_minus();
        else
          spell_number(val, 16, r.pad, 1'b0);
      end
      default: return 1'b0;
    endcase
    res.d0 = shadow_segs[0];
    res.d1 = shadow_segs[1];
    res.d2 = shadow_segs[2];
    res.d3 = shadow_segs[3];
    return 1'b1;
  endfunction

  function automatic display_req_t mk(logic [2:0] kind, int pos, int operand, int hours,
                                      int minutes, bit dots, bit padh, int pad);
    display_req_t r;
    r.kind = kind;
    r.pos = 3'(pos);
    r.operand = 17'(operand);
    r.hours = 7'(hours);
    r.minutes = 7'(minutes);
    r.dots = dots;
    r.padh = padh;
    r.pad = 3'(pad);
    return r;
  endfunction

  function automatic display_res_t shown(logic [1:0] start, logic [2:0] span, logic [7:0] d0,
                                         logic [7:0] d1, logic [7:0] d2, logic [7:0] d3);
    display_res_t res;
    res.start = start;
    res.span = span;
    res.d0 = d0;
    res.d1 = d1;
    res.d2 = d2;
    res.d3 = d3;
    return res;
  endfunction

  function automatic dir_row_t drow(display_req_t req, bit typed, bit fires,
                                    display_res_t want);
    dir_row_t row;
    row.req = req;
    row.typed = typed;
    row.fires = fires;
    row.want = want;
    return row;
  endfunction

  function automatic display_req_t random_request();
    display_req_t r;
    int op;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4)
      r.kind = (roll < 2) ? REQ_SPARE6 : REQ_SPARE7;
    else
      r.kind = 3'($urandom_range(0, 5));
    r.pos = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
    r.hours = 7'(($urandom_range(0, 9) == 0) ? $urandom_range(100, 127)
                                             : $urandom_range(0, 99));
    r.minutes = 7'(($urandom_range(0, 9) == 0) ? $urandom_range(100, 127)
                                               : $urandom_range(0, 99));
    r.dots = 1'($urandom);
    r.padh = 1'($urandom);
    r.pad = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    case ($urandom_range(0, 5))
      0: op = int'($urandom);
      1: op = $urandom_range(0, 15);
      2: op = $urandom_range(0, 9999);
      3: op = -int'($urandom_range(1, 999));
      4: op = $urandom_range(0, 65535);
      default: op = corner_operands[$urandom_range(0, 13)];
    endcase
    if (r.kind == REQ_HEX_DIGIT && $urandom_range(0, 1) == 0)
      op = $urandom_range(0, 15);
    r.operand = 17'(op);
    return r;
  endfunction

  task automatic send_request(input display_req_t r, input bit typed, input bit fires,
                              input display_res_t want);
    display_res_t calc;
    bit made;
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= r.kind;
    s_axis_tdata <= {1'b0, r.pad, r.padh, r.dots, r.minutes, r.hours, r.operand, r.pos};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    made = render_request(r, calc);
    req_count++;
    if (typed) begin
      made = fires;
      calc = want;
    end
    if (made)
      pending_displays.push_back(calc);
    else
      ignored_count++;
  endtask

  // stop sending and let every outstanding transaction come back
  task automatic settle();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_displays.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_minus(input logic [7:0] pattern);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= pattern;
    @(posedge clk_i);
    shadow_minus = pattern;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    display_res_t got;
    display_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = display_res_t'(m_axis_tdata[36:0]);
      if (pending_displays.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_displays.pop_front();
        if (got.start != want.start) report_mismatch("start_position", got.start, want.start);
        if (got.span != want.span) report_mismatch("byte_count", got.span, want.span);
        if (got.d0 != want.d0) report_mismatch("seg_digit0", got.d0, want.d0);
        if (got.d1 != want.d1) report_mismatch("seg_digit1", got.d1, want.d1);
        if (got.d2 != want.d2) report_mismatch("seg_digit2", got.d2, want.d2);
        if (got.d3 != want.d3) report_mismatch("seg_digit3", got.d3, want.d3);
      end
      checked_count++;
    end
  end

  initial begin
    int unsigned stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall != 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 6) == 0) begin
        stall = $urandom_range(1, 12) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    dir_row_t dir_rows [$];
    logic [7:0] pattern;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    gaps_on = 1'b1;
    shadow_minus = MINUS_RESET;
    for (int i = 0; i < 4; i++)
      shadow_segs[i] = SEG_BLANK;

    dir_rows.push_back(drow(mk(REQ_COLON, 0, 0, 0, 0, 1, 0, 0), 1, 1,
                            shown(2'd1, 3'd1, SEG_BLANK, COLON_BIT, SEG_BLANK, SEG_BLANK)));
    dir_rows.push_back(drow(mk(REQ_RAW, 0, 'h1FF, 0, 0, 0, 0, 0), 1, 1,
                            shown(2'd0, 3'd1, 8'hFF, COLON_BIT, SEG_BLANK, SEG_BLANK)));
    dir_rows.push_back(drow(mk(REQ_RAW, 7, 'h55, 0, 0, 0, 0, 0), 1, 0, '0));
    dir_rows.push_back(drow(mk(REQ_RAW, 3, -1, 127, 127, 1, 1, 7), 0, 0, '0));
    dir_rows.push_back(drow(mk(REQ_HEX_DIGIT, 2, 15, 0, 0, 0, 0, 0), 0, 0, '0));
    dir_rows.push_back(drow(mk(REQ_HEX_DIGIT, 1, 16, 0, 0, 0, 0, 0), 1, 0, '0));
    dir_rows.push_back(drow(mk(REQ_HEX_DIGIT, 0, -1, 0, 0, 0, 0, 0), 1, 0, '0));
    dir_rows.push_back(drow(mk(REQ_HEX_DIGIT, 4, 3, 0, 0, 0, 0, 0), 1, 0, '0));
    dir_rows.push_back(drow(mk(REQ_HEX_DIGIT, 0, 0, 0, 0, 0, 0, 0), 0, 0, '0));
    dir_rows.push_back(drow(mk(REQ_COLON, 5, 0, 0, 0, 0, 0, 0), 0, 0, '0));
    dir_rows.push_back(drow(mk(REQ_TIME, 0, 0, 99, 99, 1, 0, 0), 0, 0, '0));
    dir_rows.push_back(drow(mk(REQ_TIME, 0, 0, 127, 127, 0, 0, 0), 0, 0, '0));
    dir_rows.push_back(drow(mk(REQ_TIME, 0, 0, 5, 7, 1, 0, 0), 0, 0, '0));
    dir_rows.push_back(drow(mk(REQ_TIME, 0, 0, 5, 7, 0, 1, 0), 0, 0, '0));
    dir_rows.push_back(drow(mk(REQ_DEC, 0, 9999, 0, 0, 0, 0, 0), 0, 0, '0));
    dir_rows.push_back(drow(mk(REQ_DEC, 0, 10000, 0, 0, 0, 0, 0), 1, 1,
                            shown(2'd0, 3'd4, MINUS_RESET, MINUS_RESET, MINUS_RESET,
                                  MINUS_RESET)));
    dir_rows.push_back(drow(mk(REQ_DEC, 0, -999, 0, 0, 0, 0, 0), 0, 0, '0));
    dir_rows.push_back(drow(mk(REQ_DEC, 0, -1000, 0, 0, 0, 0, 0), 1, 1,
                            shown(2'd0, 3'd4, MINUS_RESET, MINUS_RESET, MINUS_RESET,
                                  MINUS_RESET)));
    dir_rows.push_back(drow(mk(REQ_DEC, 0, -5, 0, 0, 0, 0, 4), 0, 0, '0));
    dir_rows.push_back(drow(mk(REQ_DEC, 0, 0, 0, 0, 0, 0, 0), 1, 1,
                            shown(2'd0, 3'd4, SEG_BLANK, SEG_BLANK, SEG_BLANK, SEG_BLANK)));
    dir_rows.push_back(drow(mk(REQ_DEC, 0, 0, 0, 0, 0, 0, 7), 1, 1,
                            shown(2'd0, 3'd4, GLYPH_ZERO, GLYPH_ZERO, GLYPH_ZERO,
                                  GLYPH_ZERO)));
    dir_rows.push_back(drow(mk(REQ_DEC, 0, 42, 0, 0, 0, 0, 2), 0, 0, '0));
    dir_rows.push_back(drow(mk(REQ_HEX, 0, 65535, 0, 0, 0, 0, 0), 1, 1,
                            shown(2'd0, 3'd4, 8'h71, 8'h71, 8'h71, 8'h71)));
    dir_rows.push_back(drow(mk(REQ_HEX, 0, -32768, 0, 0, 0, 0, 0), 1, 1,
                            shown(2'd0, 3'd4, MINUS_RESET, MINUS_RESET, MINUS_RESET,
                                  MINUS_RESET)));
    dir_rows.push_back(drow(mk(REQ_HEX, 0, 0, 0, 0, 0, 0, 1), 0, 0, '0));
    dir_rows.push_back(drow(mk(REQ_SPARE6, 0, 0, 0, 0, 0, 0, 0), 1, 0, '0));
    dir_rows.push_back(drow(mk(REQ_SPARE7, 0, 0, 0, 0, 0, 0, 0), 1, 0, '0));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].fires, dir_rows[i].want);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: pattern = 8'h00;
        1: pattern = 8'hFF;
        default: pattern = 8'($urandom_range(1, 254));
      endcase
      load_minus(pattern);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // last phase runs without any idling
        if (n % 50 == 0)
          gaps_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
        send_request(random_request(), 1'b0, 1'b0, '0);
      end
    end
    settle();

    while (pending_displays.size() != 0) begin
      void'(pending_displays.pop_front());
      report_mismatch("missing result", 0, 1);
    end

    $display("sent %0d display requests (%0d dropped) under %0d minus patterns",
             req_count, ignored_count, PHASES + 1);
    $display("compared %0d result transactions, %0d field mismatches",
             checked_count, mismatch_count);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
